>>> sv/rrop_pkg.sv
// Shared types and constants for the rounded rectangle outline point generator.
// Used by rrop_phase_div, rrop_sine and rounded_rect_outline_points.
package rrop_pkg;

  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned PPC_W      = 7;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned DEFAULT_MAX_PPC    = 64;
  localparam int unsigned DEFAULT_TRIG_FRAC  = 14;

  // Phase: 2^17 is a quarter turn.
  localparam int unsigned PHASE_BITS = 17;
  localparam logic [PHASE_BITS:0] PHASE_ONE = 18'h20000;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

  // Phase divider: numerator j*2^18 + d, processed five bits per stage.
  localparam int unsigned NUM_W      = PPC_W + PHASE_BITS + 1;
  localparam int unsigned DIV_BITS   = 5;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_BITS;
  localparam int unsigned DEN_W      = PPC_W + 1;

  // Taylor series of the sine, innermost divisor first.
  localparam int unsigned TAYLOR_TERMS = 5;
  localparam logic [6:0] TAYLOR_DIV [TAYLOR_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [29:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
    30'((64'd1 << 32) / 64'd110),
    30'((64'd1 << 32) / 64'd72),
    30'((64'd1 << 32) / 64'd42),
    30'((64'd1 << 32) / 64'd20),
    30'((64'd1 << 32) / 64'd6)
  };

  localparam int unsigned SINE_LAT = 2 + 3 * TAYLOR_TERMS + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_WIDTH        = 2'd0,
    CFG_RECT_HEIGHT       = 2'd1,
    CFG_CORNER_RADIUS     = 2'd2,
    CFG_POINTS_PER_CORNER = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] corner;
    logic       in_range;
    logic       sharp;
  } side_t;

endpackage

>>> sv/rrop_phase_div.sv
// Pipelined restoring divider that turns an arc step into a quarter-turn phase.
// Depends on rrop_pkg.
module rrop_phase_div (
  input  logic                             clk_i,
  input  logic                             adv_i,
  input  logic [rrop_pkg::NUM_W-1:0]       num_i,
  input  logic [rrop_pkg::DEN_W-1:0]       den_i,
  output logic [rrop_pkg::PHASE_BITS:0]    quo_o
);

  localparam int unsigned NW = rrop_pkg::NUM_W;
  localparam int unsigned DW = rrop_pkg::DEN_W;
  localparam int unsigned NS = rrop_pkg::DIV_STAGES;

  logic [DW-1:0] rem_q [NS];
  logic [DW-1:0] den_q [NS];
  logic [NW-1:0] num_q [NS];
  logic [NW-1:0] quo_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] rem_in, den_in, rem_d;
    logic [NW-1:0] num_in, quo_in, num_d, quo_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign num_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [DW:0] trial;
      rem_d = rem_in;
      num_d = num_in;
      quo_d = quo_in;
      for (int b = 0; b < rrop_pkg::DIV_BITS; b++) begin
        trial = {rem_d, num_d[NW-1]};
        num_d = {num_d[NW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_d = DW'(trial - {1'b0, den_in});
          quo_d = {quo_d[NW-2:0], 1'b1};
        end else begin
          rem_d = trial[DW-1:0];
          quo_d = {quo_d[NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_in;
        num_q[k] <= num_d;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[NS-1][rrop_pkg::PHASE_BITS:0];

endmodule

>>> sv/rrop_sine.sv
// Pipelined sine of a quarter-turn phase: Taylor series in Q30, rounded result.
// Depends on rrop_pkg.
module rrop_sine #(
  parameter int unsigned FRAC_BITS = rrop_pkg::DEFAULT_TRIG_FRAC
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [rrop_pkg::PHASE_BITS:0] phase_i,
  output logic [FRAC_BITS:0]            sine_o
);

  localparam int unsigned NT = rrop_pkg::TAYLOR_TERMS;

  logic [rrop_pkg::PHASE_BITS:0] p_cap;
  logic [48:0] xp;
  logic [30:0] x0_q, x1_q;
  logic [31:0] x2_q;
  logic [61:0] xx;

  assign p_cap = (phase_i > rrop_pkg::PHASE_ONE) ? rrop_pkg::PHASE_ONE : phase_i;
  assign xp    = 49'(p_cap) * 49'(rrop_pkg::PI_HALF_Q30);
  assign xx    = 62'(x0_q) * 62'(x0_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x0_q <= xp[47:17];
      x1_q <= x0_q;
      x2_q <= xx[61:30];
    end
  end

  logic [30:0] it_x_q  [NT];
  logic [31:0] it_x2_q [NT];
  logic [30:0] it_t_q  [NT];

  // Each term: multiply, reciprocal multiply, then quotient correction.
  for (genvar k = 0; k < NT; k++) begin : g_term
    logic [30:0] x_in, t_in;
    logic [31:0] x2_in;
    logic [62:0] prod_a;
    logic [31:0] a_m_q, b_m_q;
    logic [30:0] a_x_q, b_x_q;
    logic [31:0] a_x2_q, b_x2_q;
    logic [61:0] recip_prod, b_rp_q;
    logic [29:0] q0;
    logic [31:0] rem;
    logic [30:0] q_fix;

    if (k == 0) begin : g_first
      assign x_in  = x1_q;
      assign x2_in = x2_q;
      assign t_in  = rrop_pkg::Q30_ONE;
    end else begin : g_next
      assign x_in  = it_x_q[k-1];
      assign x2_in = it_x2_q[k-1];
      assign t_in  = it_t_q[k-1];
    end

    assign prod_a     = 63'(x2_in) * 63'(t_in);
    assign recip_prod = 62'(a_m_q) * 62'(rrop_pkg::TAYLOR_RECIP[k]);
    assign q0         = b_rp_q[61:32];
    assign rem        = b_m_q - 32'(32'(q0) * 32'(rrop_pkg::TAYLOR_DIV[k]));
    assign q_fix      = 31'(q0) + ((rem >= 32'(rrop_pkg::TAYLOR_DIV[k])) ? 31'd1 : 31'd0);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_m_q      <= prod_a[61:30];
        a_x_q      <= x_in;
        a_x2_q     <= x2_in;
        b_rp_q     <= recip_prod;
        b_m_q      <= a_m_q;
        b_x_q      <= a_x_q;
        b_x2_q     <= a_x2_q;
        it_t_q[k]  <= rrop_pkg::Q30_ONE - q_fix;
        it_x_q[k]  <= b_x_q;
        it_x2_q[k] <= b_x2_q;
      end
    end
  end

  logic [61:0] sp;
  logic [30:0] s_q;
  logic [31:0] s_rnd;
  logic [FRAC_BITS:0] sine_q;

  assign sp    = 62'(it_x_q[NT-1]) * 62'(it_t_q[NT-1]);
  assign s_rnd = (32'(s_q) + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_q <= sp[60:30];
      if (s_rnd > (32'd1 << FRAC_BITS)) begin
        sine_q <= (FRAC_BITS+1)'(32'd1 << FRAC_BITS);
      end else begin
        sine_q <= (FRAC_BITS+1)'(s_rnd);
      end
    end
  end

  assign sine_o = sine_q;

endmodule

>>> sv/rounded_rect_outline_points.sv
// Top level of the rounded rectangle outline point generator.
// Depends on rrop_pkg, rrop_phase_div and rrop_sine.
//
// Usage: a request on the input channel carries one vertex number; the
// block answers with exactly one result carrying the vertex coordinates in
// signed Q16.0, the corner arc number and an in-range flag. Vertex numbers
// at or beyond four times the points per corner return all zeros.
// Both channels use valid and stall; a request moves at a rising edge with
// valid high and stall low. The block takes a new request in every cycle
// unless the receiver stalls, so the sustained rate is one vertex per cycle.
// From acceptance to the result being shown, a request passes one decode
// stage, five divider stages that form the arc phase, nineteen stages of the
// sine and cosine pipelines, one scaling stage and the output register.
// When the receiver stalls while a result is shown, the whole pipeline
// holds and the input stall rises in the same cycle; nothing is lost.
// Reset clears all valid bits and loads width, height and radius zero and one
// point per corner. Configuration writes take effect at once; the user must
// make them only while no request is in flight; the block does not enforce it.
module rounded_rect_outline_points #(
  parameter int unsigned MAX_POINTS_PER_CORNER = rrop_pkg::DEFAULT_MAX_PPC,
  parameter int unsigned TRIG_FRAC_BITS        = rrop_pkg::DEFAULT_TRIG_FRAC
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rrop_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rrop_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [rrop_pkg::IDX_W-1:0]           point_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rrop_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [rrop_pkg::COORD_W-1:0]  point_y_o,
  output logic [1:0]                           corner_number_o,
  output logic                                 in_range_o
);

  localparam int unsigned CW       = rrop_pkg::CFG_W;
  localparam int unsigned PW       = rrop_pkg::PPC_W;
  localparam int unsigned FB       = TRIG_FRAC_BITS;
  localparam int unsigned SIDE_LAT = rrop_pkg::DIV_STAGES + rrop_pkg::SINE_LAT;
  localparam int unsigned DEPTH    = 1 + SIDE_LAT + 2;
  localparam int unsigned PROD_W   = CW + FB + 1;

  // Configuration registers.
  logic [CW-1:0] width_q, height_q, radius_q;
  logic [PW-1:0] ppc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      radius_q <= '0;
      ppc_q    <= PW'(1);
    end else if (cfg_we_i) begin
      case (rrop_pkg::cfg_reg_e'(cfg_index_i))
        rrop_pkg::CFG_RECT_WIDTH:        width_q  <= cfg_wdata_i;
        rrop_pkg::CFG_RECT_HEIGHT:       height_q <= cfg_wdata_i;
        rrop_pkg::CFG_CORNER_RADIUS:     radius_q <= cfg_wdata_i;
        rrop_pkg::CFG_POINTS_PER_CORNER: ppc_q    <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless a shown result is stalled.
  logic [DEPTH-1:0] vld_q;
  logic adv;

  assign adv        = !vld_q[DEPTH-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Decode: effective points per corner, corner number and arc step.
  logic [PW-1:0] n_eff, j_step, d_step;
  logic [PW+1:0] n1, n2, n3, base, idx_ext;
  logic [1:0]    corner;
  logic          in_range;

  always_comb begin
    if (ppc_q == '0) begin
      n_eff = PW'(1);
    end else if (32'(ppc_q) > 32'(MAX_POINTS_PER_CORNER)) begin
      n_eff = PW'(MAX_POINTS_PER_CORNER);
    end else begin
      n_eff = ppc_q;
    end
    idx_ext  = (PW+2)'(point_index_i);
    n1       = (PW+2)'(n_eff);
    n2       = (PW+2)'(n_eff) << 1;
    n3       = n1 + n2;
    in_range = idx_ext < ((PW+2)'(n_eff) << 2);
    if (idx_ext >= n3) begin
      corner = 2'd3;
      base   = n3;
    end else if (idx_ext >= n2) begin
      corner = 2'd2;
      base   = n2;
    end else if (idx_ext >= n1) begin
      corner = 2'd1;
      base   = n1;
    end else begin
      corner = 2'd0;
      base   = '0;
    end
    j_step = PW'(idx_ext - base);
    d_step = n_eff - PW'(1);
  end

  logic [rrop_pkg::NUM_W-1:0] num_q;
  logic [rrop_pkg::DEN_W-1:0] den_q;
  rrop_pkg::side_t            dec_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q               <= (rrop_pkg::NUM_W'(j_step) << (rrop_pkg::PHASE_BITS + 1))
                             + rrop_pkg::NUM_W'(d_step);
      den_q               <= {d_step, 1'b0};
      dec_side_q.corner   <= corner;
      dec_side_q.in_range <= in_range;
      dec_side_q.sharp    <= (n_eff == PW'(1));
    end
  end

  // Phase of the arc step, then sine and cosine of it.
  logic [rrop_pkg::PHASE_BITS:0] phase, phase_c;
  logic [FB:0] sin_v, cos_v;

  rrop_phase_div u_phase_div (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (phase)
  );

  assign phase_c = rrop_pkg::PHASE_ONE - phase;

  rrop_sine #(.FRAC_BITS(FB)) u_sine (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .phase_i (phase),
    .sine_o  (sin_v)
  );

  rrop_sine #(.FRAC_BITS(FB)) u_cosine (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .phase_i (phase_c),
    .sine_o  (cos_v)
  );

  // Side information travels alongside the divider and trig pipelines.
  rrop_pkg::side_t side_q [SIDE_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= dec_side_q;
      for (int i = 1; i < SIDE_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Scale the unit offsets by the radius with round half up.
  logic [PROD_W-1:0] a_prod, b_prod;
  logic [CW-1:0]     a_q, b_q;
  rrop_pkg::side_t   sc_side_q;

  assign a_prod = PROD_W'(radius_q) * PROD_W'(cos_v) + (PROD_W'(1) << (FB - 1));
  assign b_prod = PROD_W'(radius_q) * PROD_W'(sin_v) + (PROD_W'(1) << (FB - 1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= CW'(a_prod >> FB);
      b_q       <= CW'(b_prod >> FB);
      sc_side_q <= side_q[SIDE_LAT-1];
    end
  end

  // Place the offsets around the inner corners and saturate.
  function automatic logic [rrop_pkg::COORD_W-1:0] sat_coord(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'h7FFF;
    end
    return v[15:0];
  endfunction

  logic signed [17:0] w_s, h_s, r_s, a_s, b_s, cx, cy;
  logic [rrop_pkg::COORD_W-1:0] px_d, py_d;

  always_comb begin
    w_s = $signed(18'(width_q));
    h_s = $signed(18'(height_q));
    r_s = $signed(18'(radius_q));
    a_s = $signed(18'(a_q));
    b_s = $signed(18'(b_q));
    if (sc_side_q.sharp) begin
      cx = (sc_side_q.corner == 2'd1 || sc_side_q.corner == 2'd2) ? w_s : 18'sd0;
      cy = (sc_side_q.corner[1]) ? h_s : 18'sd0;
    end else begin
      case (sc_side_q.corner)
        2'd0: begin
          cx = r_s - a_s;
          cy = r_s - b_s;
        end
        2'd1: begin
          cx = w_s - r_s + b_s;
          cy = r_s - a_s;
        end
        2'd2: begin
          cx = w_s - r_s + a_s;
          cy = h_s - r_s + b_s;
        end
        default: begin
          cx = r_s - b_s;
          cy = h_s - r_s + a_s;
        end
      endcase
    end
    px_d = sat_coord(cx);
    py_d = sat_coord(cy);
  end

  logic [rrop_pkg::COORD_W-1:0] px_q, py_q;
  logic [1:0] corner_q;
  logic       in_range_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sc_side_q.in_range) begin
        px_q       <= px_d;
        py_q       <= py_d;
        corner_q   <= sc_side_q.corner;
        in_range_q <= 1'b1;
      end else begin
        px_q       <= '0;
        py_q       <= '0;
        corner_q   <= '0;
        in_range_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = vld_q[DEPTH-1];
  assign point_x_o       = $signed(px_q);
  assign point_y_o       = $signed(py_q);
  assign corner_number_o = corner_q;
  assign in_range_o      = in_range_q;

endmodule
